// ===== rtl/crc16_byte_stuffed_framer_macros.svh =====
// ----------------------------------------------------------------------------
// Framer assertion macros
// Assertion shorthands shared by the framer checker.
// ----------------------------------------------------------------------------
`ifndef CRC16_BYTE_STUFFED_FRAMER_MACROS_SVH
`define CRC16_BYTE_STUFFED_FRAMER_MACROS_SVH

// Concurrent assertion clocked on clk and held off while reset is asserted.
`define CBSF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same check, but the consequent must hold in the cycle after the antecedent.
`define CBSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Framer package
// Types, constants and the CRC-16/MODBUS byte update shared by the framer.
// ----------------------------------------------------------------------------
package cbsf_pkg;

	localparam logic [7:0]  ESC_BYTE     = 8'h5C;
	localparam logic [7:0]  MAX_PAYLOAD  = 8'd252;
	localparam logic [7:0]  LEN_OVERHEAD = 8'd3;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		CFG_HEADER    = 2'd0,
		CFG_END       = 2'd1,
		CFG_STUFF     = 2'd2,
		CFG_CRC_ORDER = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] end_byte;
		logic       stuff_enable;
		logic       crc_high_first;
	} cfg_t;

	// One classified payload byte handed from the front to the back.
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] len_byte;
		logic       first;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} push_t;

	typedef enum logic [2:0] {
		ST_HDR,
		ST_LEN,
		ST_DATA,
		ST_CRC0,
		ST_CRC1,
		ST_END
	} state_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/cbsf_cfg.sv =====
// ----------------------------------------------------------------------------
// Framer configuration registers
// Holds the marker values and the stuffing and CRC order controls.
// ----------------------------------------------------------------------------
module cbsf_cfg import cbsf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [7:0] wr_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte    <= 8'hAA;
			cfg_q.end_byte       <= 8'h55;
			cfg_q.stuff_enable   <= 1'b1;
			cfg_q.crc_high_first <= 1'b1;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_HEADER:    cfg_q.header_byte    <= wr_data;
				CFG_END:       cfg_q.end_byte       <= wr_data;
				CFG_STUFF:     cfg_q.stuff_enable   <= wr_data[0];
				CFG_CRC_ORDER: cfg_q.crc_high_first <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/cbsf_front.sv =====
// ----------------------------------------------------------------------------
// Framer front end
// Tracks the open frame and tags each payload byte as first and/or last.
// ----------------------------------------------------------------------------
module cbsf_front import cbsf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] payload_byte,
	input  logic [7:0] payload_length,
	output push_t      push
);

	logic [7:0] bytes_left_q;
	logic [7:0] len_sat;
	logic [7:0] remaining;
	logic       first;

	always_comb begin
		if (payload_length == 8'd0) begin
			len_sat = 8'd1;
		end else if (payload_length > MAX_PAYLOAD) begin
			len_sat = MAX_PAYLOAD;
		end else begin
			len_sat = payload_length;
		end
		first     = (bytes_left_q == 8'd0);
		remaining = first ? (len_sat - 8'd1) : (bytes_left_q - 8'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 8'd0;
		end else if (accept) begin
			bytes_left_q <= remaining;
		end
	end

	assign push.valid        = accept;
	assign push.cmd.data     = payload_byte;
	assign push.cmd.len_byte = len_sat + LEN_OVERHEAD;
	assign push.cmd.first    = first;
	assign push.cmd.last     = (remaining == 8'd0);

endmodule

// ===== rtl/cbsf_queue.sv =====
// ----------------------------------------------------------------------------
// Framer command queue
// Short FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module cbsf_queue import cbsf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  logic  pop,
	output logic  full,
	output logic  head_valid,
	output cmd_t  head
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (!push.valid && pop) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ===== rtl/cbsf_back.sv =====
// ----------------------------------------------------------------------------
// Framer back end
// Expands each queued byte into framed, stuffed output beats and runs the CRC.
// ----------------------------------------------------------------------------
module cbsf_back import cbsf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       head_valid,
	input  cmd_t       head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_done
);

	state_t      st_q, st_next, cur_st;
	logic        esc_q, esc_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] crc_hdr, crc_data;
	logic        adv;
	logic [7:0]  cand;
	logic        stuff_state;
	logic        esc_need;
	logic [7:0]  byte_d;
	logic        last_d, done_d, final_d;
	logic        ov_q;
	logic [7:0]  byte_q;
	logic        last_q, done_q;

	// A byte that does not open a frame starts straight at its data step.
	assign cur_st = (st_q == ST_HDR && !head.first) ? ST_DATA : st_q;
	assign adv    = head_valid && (!ov_q || out_ready);

	assign crc_hdr  = crc_update(CRC_INIT, head.len_byte);
	assign crc_data = crc_update(crc_q, head.data);

	always_comb begin
		case (cur_st)
			ST_DATA: cand = head.data;
			ST_CRC0: cand = cfg.crc_high_first ? crc_q[15:8] : crc_q[7:0];
			ST_CRC1: cand = cfg.crc_high_first ? crc_q[7:0] : crc_q[15:8];
			default: cand = 8'h00;
		endcase
		stuff_state = (cur_st == ST_DATA) || (cur_st == ST_CRC0) || (cur_st == ST_CRC1);
		esc_need    = stuff_state && cfg.stuff_enable && !esc_q && (cand != ESC_BYTE)
		              && ((cand == cfg.header_byte) || (cand == cfg.end_byte));
	end

	always_comb begin
		st_next = st_q;
		unique case (cur_st)
			ST_HDR:  st_next = ST_LEN;
			ST_LEN:  st_next = ST_DATA;
			ST_DATA: st_next = esc_need ? ST_DATA : (head.last ? ST_CRC0 : ST_HDR);
			ST_CRC0: st_next = esc_need ? ST_CRC0 : ST_CRC1;
			ST_CRC1: st_next = esc_need ? ST_CRC1 : ST_END;
			ST_END:  st_next = ST_HDR;
			default: st_next = ST_HDR;
		endcase
	end

	always_comb begin
		byte_d  = 8'h00;
		last_d  = 1'b0;
		done_d  = 1'b0;
		final_d = 1'b0;
		crc_d   = crc_q;
		esc_d   = esc_need;
		unique case (cur_st)
			ST_HDR: begin
				byte_d = cfg.header_byte;
				crc_d  = crc_hdr;
			end
			ST_LEN: begin
				byte_d = head.len_byte;
			end
			ST_DATA: begin
				byte_d  = esc_need ? ESC_BYTE : head.data;
				last_d  = !esc_need && !head.last;
				final_d = !esc_need && !head.last;
				if (!esc_need) begin
					crc_d = crc_data;
				end
			end
			ST_CRC0, ST_CRC1: begin
				byte_d = esc_need ? ESC_BYTE : cand;
			end
			ST_END: begin
				byte_d  = cfg.end_byte;
				last_d  = 1'b1;
				done_d  = 1'b1;
				final_d = 1'b1;
				crc_d   = CRC_INIT;
			end
			default: ;
		endcase
	end

	assign pop = adv && final_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_HDR;
			esc_q <= 1'b0;
			crc_q <= CRC_INIT;
			ov_q  <= 1'b0;
		end else begin
			if (adv) begin
				st_q  <= st_next;
				esc_q <= esc_d;
				crc_q <= crc_d;
				ov_q  <= 1'b1;
			end else if (out_ready) begin
				ov_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= byte_d;
			last_q <= last_d;
			done_q <= done_d;
		end
	end

	assign out_valid  = ov_q;
	assign out_byte   = byte_q;
	assign run_last   = last_q;
	assign frame_done = done_q;

endmodule

// ===== rtl/crc16_byte_stuffed_framer.sv =====
// ----------------------------------------------------------------------------
// CRC-16 byte-stuffed framer
// Builds serial frames of header, length, payload, CRC-16/MODBUS and end byte.
// ----------------------------------------------------------------------------
// Path: an accepted input beat is written into the command queue; the back end then
// registers each output beat of the item from the queue head in its byte register.
// Throughput: one output beat per cycle while the queue holds an item and m_tready
// is high, set by the single output byte register; an item yields 1 to 9 bytes.
// Input beats are taken whenever the two-entry command queue has room.
// Reset (arst_n low, asynchronous) closes any open frame, empties the queue and
// output register, and returns the registers to header 0xAA, end 0x55, stuffing on,
// CRC high byte first.
// ----------------------------------------------------------------------------
module crc16_byte_stuffed_framer import cbsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Payload input.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [7:0] payload_byte, [15:8] payload_length
	// Framed output.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] out_byte
	output logic        m_tlast,    // run_last
	output logic        m_tuser,    // [0] frame_done
	// Register writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t  cfg;
	push_t push;
	logic  q_full;
	logic  q_head_valid;
	cmd_t  q_head;
	logic  q_pop;
	logic  s_accept;

	// Always accepted, unenforced: the user must write only while the framer is idle.
	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign s_accept  = s_tvalid && s_tready;

	cbsf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The front end counts the payload bytes of the open frame and marks
	// the byte that opens a frame and the one that closes it.
	cbsf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (s_accept),
		.payload_byte   (s_tdata[7:0]),
		.payload_length (s_tdata[15:8]),
		.push           (push)
	);

	// The queue lets the input side keep accepting while a long expansion,
	// such as the CRC and end bytes of a frame, drains on the output side.
	cbsf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// The back end walks header, length, data, CRC and end steps and, with stuffing on,
	// puts the escape byte ahead of a marker-valued data or CRC byte that is not 0x5C.
	cbsf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.run_last   (m_tlast),
		.frame_done (m_tuser)
	);

endmodule

// ===== rtl/cbsf_checker.sv =====
// ----------------------------------------------------------------------------
// Framer port checker
// Watches the framer's output port over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "crc16_byte_stuffed_framer_macros.svh"

module cbsf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	// The end marker always closes the run of its input item.
	`CBSF_ASSERT(a_done_is_last, (m_tvalid && m_tuser) |-> m_tlast, "frame end without tlast")

	// An accepted end marker must never be followed straight away by another one.
	`CBSF_ASSERT_NEXT(a_no_double_end, m_tvalid && m_tready && m_tuser, !(m_tvalid && m_tuser), "two frame ends in a row")

	// A stalled output beat keeps its data byte.
	`CBSF_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled tdata changed")

	// A stalled output beat keeps its flags.
	`CBSF_ASSERT_NEXT(a_hold_flags, m_tvalid && !m_tready, $stable(m_tlast) && $stable(m_tuser), "stalled flags changed")

endmodule

bind crc16_byte_stuffed_framer cbsf_checker u_cbsf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the CRC-16 byte-stuffed framer
// Drives payload beats and register writes into the framer and predicts each
// framed output beat: header, length, payload with optional escape bytes,
// CRC-16/MODBUS in the selected byte order, and the end marker. A scoreboard
// compares every output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import cbsf_pkg::*;

	localparam logic [7:0]  ESCAPE_MARK      = 8'h5C;
	localparam logic [7:0]  PAYLOAD_CAP      = 8'd252;
	localparam logic [15:0] CRC_SEED         = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_REV     = 16'hA001;
	localparam int          CYCLE_LIMIT      = 400000;
	localparam int          SETTLE_CYCLES    = 6;
	localparam int          RANDOM_PER_PHASE = 4;
	localparam int          PRINT_LIMIT      = 20;

	// One predicted output beat of the framed stream.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_done;
	} framed_beat_t;

	// The scoreboard carries its own copy of the framer state and registers.
	// Every accepted payload beat is expanded into the beats it must produce,
	// and every output beat is checked against the oldest of those.
	class frame_scoreboard;
		logic [7:0]   header_mark;
		logic [7:0]   end_mark;
		logic         stuff_on;
		logic         crc_high_first;
		logic [7:0]   bytes_left;
		logic [15:0]  crc_acc;
		framed_beat_t pending[$];
		int           errors;
		int           payload_beats;
		int           framed_beats;
		int           frames_closed;
		int           escapes;
		int           reg_writes;

		function new();
			header_mark    = 8'hAA;
			end_mark       = 8'h55;
			stuff_on       = 1'b1;
			crc_high_first = 1'b1;
			bytes_left     = 8'd0;
			crc_acc        = CRC_SEED;
			errors         = 0;
			payload_beats  = 0;
			framed_beats   = 0;
			frames_closed  = 0;
			escapes        = 0;
			reg_writes     = 0;
		endfunction

		// Bit-serial form of the reflected CRC: each data bit meets the
		// register LSB at the moment it would have been shifted down there.
		function logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
			logic [15:0] r;
			logic        fb;
			r = c;
			for (int i = 0; i < 8; i++) begin
				fb = r[0] ^ b[i];
				r  = r >> 1;
				if (fb) begin
					r = r ^ CRC_POLY_REV;
				end
			end
			return r;
		endfunction

		function void set_register(input cfg_idx_t idx, input logic [7:0] v);
			reg_writes++;
			case (idx)
				CFG_HEADER: begin
					header_mark = v;
				end
				CFG_END: begin
					end_mark = v;
				end
				CFG_STUFF: begin
					stuff_on = v[0];
				end
				CFG_CRC_ORDER: begin
					crc_high_first = v[0];
				end
				default: begin
				end
			endcase
		endfunction

		function void push_beat(input logic [7:0] b, input logic done);
			framed_beat_t e;
			e.out_byte   = b;
			e.run_last   = 1'b0;
			e.frame_done = done;
			pending.push_back(e);
		endfunction

		// The escape byte itself never gets escaped, even if a marker equals it.
		function void push_escaped(input logic [7:0] b);
			if (stuff_on && (b == header_mark || b == end_mark) && b != ESCAPE_MARK) begin
				push_beat(ESCAPE_MARK, 1'b0);
				escapes++;
			end
			push_beat(b, 1'b0);
		endfunction

		function void note_payload(input logic [7:0] data, input logic [7:0] len_field);
			logic [7:0] n;
			logic [7:0] len_b;
			payload_beats++;
			if (bytes_left == 8'd0) begin
				// The length is only looked at when a frame opens; zero counts
				// as one and anything past the cap is clipped to the cap.
				n = len_field;
				if (n == 8'd0) begin
					n = 8'd1;
				end
				if (n > PAYLOAD_CAP) begin
					n = PAYLOAD_CAP;
				end
				len_b = n + 8'd3;
				push_beat(header_mark, 1'b0);
				push_beat(len_b, 1'b0);
				crc_acc    = crc_next(CRC_SEED, len_b);
				bytes_left = n;
			end
			push_escaped(data);
			crc_acc    = crc_next(crc_acc, data);
			bytes_left = bytes_left - 8'd1;
			if (bytes_left == 8'd0) begin
				if (crc_high_first) begin
					push_escaped(crc_acc[15:8]);
					push_escaped(crc_acc[7:0]);
				end else begin
					push_escaped(crc_acc[7:0]);
					push_escaped(crc_acc[15:8]);
				end
				push_beat(end_mark, 1'b1);
				crc_acc = CRC_SEED;
				frames_closed++;
			end
			pending[pending.size() - 1].run_last = 1'b1;
		endfunction

		task report(input string what);
			errors++;
			if (errors <= PRINT_LIMIT) begin
				$display("[%0t] framer output error: %s", $realtime, what);
			end
		endtask

		task check_beat(input logic [7:0] b, input logic last, input logic done);
			framed_beat_t e;
			if (pending.size() == 0) begin
				report($sformatf("beat %02h arrived with nothing outstanding", b));
				return;
			end
			e = pending.pop_front();
			framed_beats++;
			if (b !== e.out_byte) begin
				report($sformatf("out_byte %02h, predicted %02h", b, e.out_byte));
			end
			if (last !== e.run_last) begin
				report($sformatf("run_last %b, predicted %b on byte %02h",
					last, e.run_last, e.out_byte));
			end
			if (done !== e.frame_done) begin
				report($sformatf("frame_done %b, predicted %b on byte %02h",
					done, e.frame_done, e.out_byte));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	frame_scoreboard sb;
	int              idle_pct;
	int              cycle_count;

	crc16_byte_stuffed_framer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),     // [7:0] payload_byte, [15:8] payload_length
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),     // [7:0] out_byte
		.m_tlast   (m_tlast),     // run_last
		.m_tuser   (m_tuser),     // [0] frame_done
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Output side: every beat that completes a handshake goes to the scoreboard.
	// The ready line is rerolled every cycle, so stalls land on every phase of
	// a frame; with idle_pct at zero the sink never holds back.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_beat(m_tdata, m_tlast, m_tuser);
		end
		m_tready <= ($urandom_range(0, 99) >= idle_pct);
	end

	// Hard stop in case the framer hangs or loses beats.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d beats outstanding.",
				cycle_count, sb.pending.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// One payload beat. A random number of idle cycles goes before it; the
	// valid line is only lowered when such a gap is actually taken, so
	// back-to-back beats keep it high.
	task automatic send_payload(input logic [7:0] b, input logic [7:0] len);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {len, b};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		sb.note_payload(b, len);
	endtask

	// Hold the input side until every predicted beat has come out, then let the
	// pipeline settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) begin
			@(posedge clk);
		end
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		sb.set_register(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// The one-bit registers get random upper data bits, which must be ignored.
	task automatic apply_settings(input logic [7:0] hdr, input logic [7:0] trl,
		input logic stuff, input logic high_first);
		logic [6:0] junk;
		drain();
		write_register(CFG_HEADER, hdr);
		write_register(CFG_END, trl);
		junk = 7'($urandom_range(0, 127));
		write_register(CFG_STUFF, {junk, stuff});
		junk = 7'($urandom_range(0, 127));
		write_register(CFG_CRC_ORDER, {junk, high_first});
	endtask

	// A random payload beat. Lengths that open a frame are mostly short, with
	// zero now and then. A quarter of the data bytes copy a marker or the
	// escape value, and the closing byte of a frame is sometimes chosen so
	// that one of the CRC bytes lands on a marker.
	task automatic send_random_item();
		logic [7:0]  b;
		logic [7:0]  len;
		logic [7:0]  target;
		logic [15:0] c;
		logic        found;
		int          r;
		if (sb.bytes_left == 8'd0) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				len = 8'd0;
			end else if (r < 80) begin
				len = 8'($urandom_range(1, 6));
			end else begin
				len = 8'($urandom_range(7, 24));
			end
		end else begin
			len = 8'($urandom_range(0, 255));
		end
		b = 8'($urandom_range(0, 255));
		if (sb.bytes_left == 8'd1 && $urandom_range(0, 2) == 0) begin
			target = $urandom_range(0, 1) ? sb.header_mark : sb.end_mark;
			found  = 1'b0;
			for (int v = 0; v < 256; v++) begin
				c = sb.crc_next(sb.crc_acc, v[7:0]);
				if (!found && (c[15:8] == target || c[7:0] == target)) begin
					b     = v[7:0];
					found = 1'b1;
				end
			end
		end else if ($urandom_range(0, 3) == 0) begin
			r = $urandom_range(0, 2);
			if (r == 0) begin
				b = sb.header_mark;
			end else if (r == 1) begin
				b = sb.end_mark;
			end else begin
				b = ESCAPE_MARK;
			end
		end
		send_payload(b, len);
	endtask

	initial begin
		sb          = new();
		idle_pct    = 38;
		cycle_count = 0;
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= 16'h0000;
		m_tready    <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= CFG_HEADER;
		cfg_data    <= 8'h00;
		repeat (8) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings. A zero length makes a one-byte frame; then plain
		// bytes, both marker values as payload, and the escape value as data.
		send_payload(8'h00, 8'h00);
		send_payload(8'hFF, 8'h01);
		send_payload(8'hAA, 8'h02);
		send_payload(8'h55, 8'hFF);
		send_payload(8'h5C, 8'h03);
		send_payload(8'h00, 8'h80);
		send_payload(8'hFF, 8'h7F);

		// Both markers equal to the escape value, CRC low byte first.
		apply_settings(8'h5C, 8'h5C, 1'b1, 1'b0);
		send_payload(8'h5C, 8'h02);
		send_payload(8'hAA, 8'h00);

		// Stuffing off: marker-valued payload goes out unchanged.
		apply_settings(8'h00, 8'hFF, 1'b0, 1'b1);
		send_payload(8'h00, 8'h03);
		send_payload(8'hFF, 8'hFF);
		send_payload(8'h12, 8'h00);

		// Registers rewritten while a frame is open: the second half of the
		// frame and its CRC follow the new settings.
		send_payload(8'h7E, 8'h04);
		send_payload(8'h7D, 8'h00);
		apply_settings(8'h7E, 8'h7D, 1'b1, 1'b1);
		send_payload(8'h7E, 8'h00);
		send_payload(8'h7D, 8'h00);

		// Oversized length clipped to the cap, run as one frame with neither
		// side ever idling.
		apply_settings(8'h7E, 8'h7D, 1'b1, 1'b0);
		idle_pct = 0;
		send_payload(8'hA5, 8'hFF);
		repeat (PAYLOAD_CAP - 1) begin
			send_random_item();
		end
		drain();
		idle_pct = 38;

		// Random frames, each phase under its own register settings; the
		// first phases take the extreme marker values.
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin
					apply_settings(8'h00, 8'hFF, 1'b1, 1'b0);
				end
				1: begin
					apply_settings(8'hFF, 8'h00, 1'b1, 1'b1);
				end
				2: begin
					apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						1'b0, 1'($urandom_range(0, 1)));
				end
				3: begin
					apply_settings(8'h5C, 8'($urandom_range(0, 255)), 1'b1,
						1'($urandom_range(0, 1)));
				end
				default: begin
					apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			endcase
			repeat (RANDOM_PER_PHASE) begin
				send_random_item();
			end
		end

		drain();
		repeat (20) begin
			@(posedge clk);
		end
		$display("Sent %0d payload beats, checked %0d framed beats in %0d closed frames %s",
			sb.payload_beats, sb.framed_beats, sb.frames_closed,
			$sformatf("(%0d escapes).", sb.escapes));
		$display("Made %0d register writes: reset values, extreme and escape-valued %s",
			sb.reg_writes, "markers, stuffing off, both CRC orders.");
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
